// File: rtl/plrs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// plrs_pkg
// Shared types and constants of the pinned lowest-RTT path selector.
// ----------------------------------------------------------------------------
package plrs_pkg;

    localparam int MAX_PATHS = 8;
    localparam int SLOT_W    = 3;
    localparam int MASK_W    = 8;
    localparam int PORT_W    = 16;
    localparam int IF_W      = 16;
    localparam int SRTT_W    = 32;
    localparam int RTT_SHIFT = 3;
    localparam int RTT_W     = SRTT_W - RTT_SHIFT;
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 2;

    localparam logic [PORT_W-1:0] REDUNDANT_PORT_RST = PORT_W'(5000);

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_REDUNDANT_PORT    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PIN_IF_REDUNDANT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PIN_IF_LOWEST_RTT = 2'd2;

    // result status codes
    localparam logic [1:0] OUTCOME_NORMAL   = 2'd0;
    localparam logic [1:0] OUTCOME_FALLBACK = 2'd1;
    localparam logic [1:0] OUTCOME_NONE     = 2'd2;

    // commands from the controller to the datapath
    typedef struct packed {
        logic take;    // a record word is accepted this cycle
        logic first;   // that word opens a set
        logic finish;  // evaluate the set and clear it
    } t_cmd;

endpackage
`default_nettype wire

// File: rtl/pinned_lowest_rtt_path_selector_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pinned_lowest_rtt_path_selector_core
// Multipath scheduler: takes one path record per cycle while not busy, picks the lowest
// smoothed RTT path (or all paths in redundant mode), honoring a pinned
// interface with fallback to the best path overall.
// ----------------------------------------------------------------------------
// result: the closing record moves the sequencer to its evaluation state, and the result
// word is registered from that state; one record is taken per cycle while busy is low,
//   busy is high for the single evaluation cycle after the closing record
// the receiver cannot stall; results are one-cycle strobes
// reset: control, configuration and per-set registers return to their defaults, any partial set is dropped
module pinned_lowest_rtt_path_selector_core (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              start,
    output logic                                   busy,
    input  wire logic                              i_cfg_we,
    input  wire logic [plrs_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  wire logic [plrs_pkg::CFG_W-1:0]        i_cfg_data,
    input  wire logic [plrs_pkg::SLOT_W-1:0]       i_path_slot,
    input  wire logic                              i_path_active,
    input  wire logic                              i_buffer_free,
    input  wire logic [plrs_pkg::IF_W-1:0]         i_bound_interface,
    input  wire logic [plrs_pkg::SRTT_W-1:0]       i_smoothed_rtt,
    input  wire logic [plrs_pkg::PORT_W-1:0]       i_remote_port,
    input  wire logic [plrs_pkg::PORT_W-1:0]       i_local_port,
    input  wire logic                              i_last_path,
    output logic                                   o_valid,
    output logic                                   o_replicated,
    output logic [plrs_pkg::MASK_W-1:0]            o_scheduled_mask,
    output logic [plrs_pkg::SLOT_W-1:0]            o_chosen_slot,
    output logic [1:0]                             o_outcome
);
    import plrs_pkg::*;

    t_cmd cmd;

    plrs_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .i_last_path (i_last_path),
        .o_cmd       (cmd),
        .o_busy      (busy)
    );

    plrs_datapath u_datapath (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_idx         (i_cfg_idx),
        .i_cfg_data        (i_cfg_data),
        .i_path_slot       (i_path_slot),
        .i_path_active     (i_path_active),
        .i_buffer_free     (i_buffer_free),
        .i_bound_interface (i_bound_interface),
        .i_smoothed_rtt    (i_smoothed_rtt),
        .i_remote_port     (i_remote_port),
        .i_local_port      (i_local_port),
        .o_valid           (o_valid),
        .o_replicated      (o_replicated),
        .o_scheduled_mask  (o_scheduled_mask),
        .o_chosen_slot     (o_chosen_slot),
        .o_outcome         (o_outcome)
    );

endmodule
`default_nettype wire

// File: rtl/plrs_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// plrs_ctrl
// Set sequencer: tracks the first record, the closing record and the
// evaluation cycle, and issues commands to the datapath.
// ----------------------------------------------------------------------------
module plrs_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_start,
    input  wire logic          i_last_path,
    output plrs_pkg::t_cmd     o_cmd,
    output logic               o_busy
);
    import plrs_pkg::*;

    typedef enum logic [2:0] {
        S_FIRST = 3'b001,
        S_REST  = 3'b010,
        S_DONE  = 3'b100
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   take;

    assign o_busy = (r_state == S_DONE);
    assign take   = i_start && !o_busy;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_FIRST, S_REST: begin
                if (take) begin
                    n_state = i_last_path ? S_DONE : S_REST;
                end
            end
            S_DONE: begin
                n_state = S_FIRST;
            end
            default: begin
                n_state = S_FIRST;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_FIRST;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_cmd.take   = take;
    assign o_cmd.first  = (r_state == S_FIRST);
    assign o_cmd.finish = (r_state == S_DONE);

`ifndef NO_ASSERTIONS
    // evaluation lasts exactly one cycle
    a_done_one_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_busy |=> !o_busy)
        else $error("busy held for more than one cycle");

    // a closing record always leads to evaluation
    a_last_to_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        take && i_last_path |=> o_busy)
        else $error("closing record not followed by evaluation");

    // no record is taken while evaluating
    a_no_take_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.finish |-> !o_cmd.take)
        else $error("record taken during evaluation");
`endif

endmodule
`default_nettype wire

// File: rtl/plrs_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// plrs_datapath
// Configuration registers, per-set accumulators (best RTTs, slot masks,
// latched mode) and the registered result word.
// ----------------------------------------------------------------------------
module plrs_datapath (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire plrs_pkg::t_cmd                    i_cmd,
    input  wire logic                              i_cfg_we,
    input  wire logic [plrs_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  wire logic [plrs_pkg::CFG_W-1:0]        i_cfg_data,
    input  wire logic [plrs_pkg::SLOT_W-1:0]       i_path_slot,
    input  wire logic                              i_path_active,
    input  wire logic                              i_buffer_free,
    input  wire logic [plrs_pkg::IF_W-1:0]         i_bound_interface,
    input  wire logic [plrs_pkg::SRTT_W-1:0]       i_smoothed_rtt,
    input  wire logic [plrs_pkg::PORT_W-1:0]       i_remote_port,
    input  wire logic [plrs_pkg::PORT_W-1:0]       i_local_port,
    output logic                                   o_valid,
    output logic                                   o_replicated,
    output logic [plrs_pkg::MASK_W-1:0]            o_scheduled_mask,
    output logic [plrs_pkg::SLOT_W-1:0]            o_chosen_slot,
    output logic [1:0]                             o_outcome
);
    import plrs_pkg::*;

    // configuration
    logic [PORT_W-1:0] r_redundant_port;
    logic [IF_W-1:0]   r_pin_if_redundant;
    logic [IF_W-1:0]   r_pin_if_lowest_rtt;

    // per-set state
    logic              r_mode;
    logic [RTT_W-1:0]  r_pin_rtt;
    logic              r_pin_vld;
    logic [SLOT_W-1:0] r_pin_slot;
    logic [RTT_W-1:0]  r_all_rtt;
    logic              r_all_vld;
    logic [SLOT_W-1:0] r_all_slot;
    logic              r_any;
    logic [MASK_W-1:0] r_pin_mask;
    logic [MASK_W-1:0] r_all_mask;

    // result word
    logic              r_valid;
    logic              r_res_mode;
    logic [MASK_W-1:0] r_res_mask;
    logic [SLOT_W-1:0] r_res_slot;
    logic [1:0]        r_res_outcome;

    logic              mode;
    logic [IF_W-1:0]   pin;
    logic              on_pin;
    logic              slot_ok;
    logic [MASK_W-1:0] slot_bit;
    logic [RTT_W-1:0]  rtt;
    logic              usable;
    logic              upd_all;
    logic              upd_pin;
    logic [MASK_W-1:0] n_mask;
    logic [SLOT_W-1:0] n_slot;
    logic [1:0]        n_outcome;

    // mode comes from the ports of the opening record
    assign mode = i_cmd.first ? ((i_remote_port == r_redundant_port) ||
                                 (i_local_port == r_redundant_port))
                              : r_mode;
    assign pin      = mode ? r_pin_if_redundant : r_pin_if_lowest_rtt;
    assign on_pin   = (pin == '0) || (i_bound_interface == pin);
    assign slot_ok  = int'(i_path_slot) < MAX_PATHS;
    assign slot_bit = MASK_W'(1) << i_path_slot;
    assign rtt      = i_smoothed_rtt[SRTT_W-1:RTT_SHIFT];
    assign usable   = slot_ok && !mode && i_path_active && i_buffer_free;
    assign upd_all  = usable && (!r_all_vld || (rtt < r_all_rtt));
    assign upd_pin  = usable && on_pin && (!r_pin_vld || (rtt < r_pin_rtt));

    // set evaluation, with r_mode already latched
    always_comb begin
        n_mask    = '0;
        n_slot    = '0;
        n_outcome = OUTCOME_NONE;
        if (r_mode) begin
            if (r_pin_mask != '0) begin
                n_mask    = r_pin_mask;
                n_outcome = OUTCOME_NORMAL;
            end else if ((r_pin_if_redundant != '0) && r_any) begin
                n_mask    = r_all_mask;
                n_outcome = OUTCOME_FALLBACK;
            end
        end else begin
            if (r_pin_vld) begin
                n_slot    = r_pin_slot;
                n_mask    = MASK_W'(1) << r_pin_slot;
                n_outcome = OUTCOME_NORMAL;
            end else if ((r_pin_if_lowest_rtt != '0) && r_any && r_all_vld) begin
                n_slot    = r_all_slot;
                n_mask    = MASK_W'(1) << r_all_slot;
                n_outcome = OUTCOME_FALLBACK;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_redundant_port    <= REDUNDANT_PORT_RST;
            r_pin_if_redundant  <= '0;
            r_pin_if_lowest_rtt <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_REDUNDANT_PORT:    r_redundant_port    <= i_cfg_data;
                CFG_PIN_IF_REDUNDANT:  r_pin_if_redundant  <= i_cfg_data;
                CFG_PIN_IF_LOWEST_RTT: r_pin_if_lowest_rtt <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.finish) begin
            r_mode     <= 1'b0;
            r_pin_rtt  <= '1;
            r_pin_vld  <= 1'b0;
            r_pin_slot <= '0;
            r_all_rtt  <= '1;
            r_all_vld  <= 1'b0;
            r_all_slot <= '0;
            r_any      <= 1'b0;
            r_pin_mask <= '0;
            r_all_mask <= '0;
        end else if (i_cmd.take) begin
            r_mode <= mode;
            if (slot_ok && mode) begin
                r_any      <= 1'b1;
                r_all_mask <= r_all_mask | slot_bit;
                if (on_pin) begin
                    r_pin_mask <= r_pin_mask | slot_bit;
                end
            end
            if (usable) begin
                r_any <= 1'b1;
            end
            if (upd_all) begin
                r_all_rtt  <= rtt;
                r_all_vld  <= 1'b1;
                r_all_slot <= i_path_slot;
            end
            if (upd_pin) begin
                r_pin_rtt  <= rtt;
                r_pin_vld  <= 1'b1;
                r_pin_slot <= i_path_slot;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_cmd.finish;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_res_mode    <= r_mode;
            r_res_mask    <= n_mask;
            r_res_slot    <= n_slot;
            r_res_outcome <= n_outcome;
        end
    end

    assign o_valid          = r_valid;
    assign o_replicated     = r_res_mode;
    assign o_scheduled_mask = r_res_mask;
    assign o_chosen_slot    = r_res_slot;
    assign o_outcome        = r_res_outcome;

`ifndef NO_ASSERTIONS
    // one word per set, never two in a row
    a_valid_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe longer than one cycle");

    // no usable path means nothing scheduled
    a_none_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_outcome == OUTCOME_NONE) |-> (o_scheduled_mask == '0))
        else $error("mask set with no usable path");

    // lowest-rtt picks exactly one path, the chosen slot
    a_rtt_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_replicated && (o_outcome != OUTCOME_NONE)
        |-> $onehot(o_scheduled_mask) && o_scheduled_mask[o_chosen_slot])
        else $error("lowest-rtt mask does not match chosen slot");

    // redundant mode never reports a slot
    a_red_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_replicated |-> (o_chosen_slot == '0))
        else $error("slot reported in redundant mode");
`endif

endmodule
`default_nettype wire
